### rtl/psc_pkg.sv
// shared types and constants for the pid servo controller
package psc_pkg;

   // configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type REG_SETPOINT     = 3'd0;
   localparam csr_index_type REG_PROP_GAIN    = 3'd1;
   localparam csr_index_type REG_INTEG_GAIN   = 3'd2;
   localparam csr_index_type REG_DERIV_GAIN   = 3'd3;
   localparam csr_index_type REG_OUT_DIVISOR  = 3'd4;
   localparam csr_index_type REG_DEFAULT_BAND = 3'd5;
   localparam csr_index_type REG_ERROR_BAND   = 3'd6;
   localparam csr_index_type REG_RATE_BAND    = 3'd7;

   // width of the pid sum accumulator
   localparam int ACC_W = 96;
   // divider data width and step counter width
   localparam int DIV_W = 32;
   localparam int DIV_CNT_W = 6;
   // quotient bits kept for the drive; anything larger clamps anyway
   localparam int QUOT_W = 24;

   // divider command
   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_W-1:0]     rem_init;
      logic [DIV_W-1:0]     dividend;
      logic [DIV_W-1:0]     divisor;
   } div_req_type;

   // divider status
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic             rem_nz;
   } div_rsp_type;

   // sequencer states, one-hot
   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_PREP    = 14'b00000000000010,
      S_MUL_ED  = 14'b00000000000100,
      S_INTEG   = 14'b00000000001000,
      S_RDIV    = 14'b00000000010000,
      S_MUL_P   = 14'b00000000100000,
      S_MUL_IL  = 14'b00000001000000,
      S_MUL_IH  = 14'b00000010000000,
      S_MUL_D   = 14'b00000100000000,
      S_ACC_D   = 14'b00001000000000,
      S_NEG     = 14'b00010000000000,
      S_DDIV_LD = 14'b00100000000000,
      S_DDIV    = 14'b01000000000000,
      S_FIN     = 14'b10000000000000
   } state_type;

endpackage

### rtl/psc_divider.sv
// shared restoring divider, one quotient bit per cycle
module psc_divider
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_W:0]       trial;
   logic                 ge;

   // one trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = div_req.rem_init;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_W'(trial - {1'b0, dsr_ff}) : trial[DIV_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;
   assign div_rsp.rem_nz   = rem_ff != '0;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider finished without done");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero steps left");

endmodule

### rtl/pid_servo_controller.sv
// pid servo controller with variable time step: top level and sequencer
// the rate division and the drive division share one divider; when the drive quotient is
//   out of range the drive division is skipped and the drive clamps
// one item at a time: a new item is accepted only in the idle state, after the last result is registered
// a finished result waits in the output register while the next item is accepted
// reset: synchronous; gains and bands go to 0, divisor to 1, all history to 0
module pid_servo_controller
   import psc_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16,
   parameter int DRIVE_MAX      = 180,
   parameter int DRIVE_CENTER   = 90,
   localparam int DRIVE_W       = $clog2(DRIVE_MAX + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_measurement,
   input  logic [31:0]        req_timestamp_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DRIVE_W-1:0] rsp_drive,
   output logic signed [31:0] rsp_error_now,
   output logic signed [31:0] rsp_rate_now,
   output logic               rsp_settled_default,
   output logic               rsp_settled_both,
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);
   localparam int VW = QUOT_W + 20;
   localparam logic signed [VW-1:0] CENTER_V = VW'(DRIVE_CENTER);
   localparam logic signed [VW-1:0] MAX_V    = VW'(DRIVE_MAX);

   state_type state_ff, state_in;

   // configuration registers
   logic signed [31:0] setpoint_ff, prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [15:0]        out_divisor_ff;
   logic [30:0]        default_band_ff, error_band_ff, rate_band_ff;

   // history
   logic [31:0]        prev_time_ff;
   logic signed [31:0] prev_error_ff;
   logic signed [63:0] integ_ff, integ_in;

   // per item work registers
   logic signed [31:0] meas_ff;
   logic [31:0]        ts_ff;
   logic signed [31:0] e_ff;
   logic [31:0]        dt_ff;
   logic               rneg_ff;
   logic signed [31:0] r_ff, r_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]   mag_ff;
   logic               sneg_ff, ovf_ff, lownz_ff;

   // output register
   logic               rsp_valid_ff;
   logic [DRIVE_W-1:0] rsp_drive_ff;
   logic signed [31:0] rsp_error_ff, rsp_rate_ff;
   logic               rsp_sd_ff, rsp_sb_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0]        dt_raw;
   logic signed [32:0] rdiff;
   logic [31:0]        rmag;
   logic signed [64:0] isum;
   logic signed [32:0] mul_a, mul_b;
   logic signed [ACC_W-1:0] prod_ext;
   logic [ACC_W-1:0]   quo_src, quo_hi;
   logic [15:0]        div_eff;
   logic               ovf_w;
   logic [QUOT_W:0]    qmag;
   logic signed [VW-1:0] vsum;
   logic [DRIVE_W-1:0] drive_w;
   logic signed [32:0] e_w, r_w, db_w, eb_w, rb_w;
   logic               sd_w, sb_w, out_free;

   psc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = state_ff == S_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // elapsed time, zero counts as one
   assign dt_raw = ts_ff - prev_time_ff;

   // rate numerator sign and magnitude
   assign rdiff = 33'(e_ff) - 33'(prev_error_ff);
   assign rmag  = rdiff[32] ? 32'(-rdiff) : 32'(rdiff);

   // saturating integral add
   assign isum = 65'(integ_ff) + 65'($signed(prod_ff[63:0]));

   // shared multiplier operand select
   always_comb begin
      mul_a = 33'(e_ff);
      mul_b = {1'b0, dt_ff};
      case (state_ff)
         S_MUL_P: begin
            mul_a = 33'(prop_gain_ff);
            mul_b = 33'(e_ff);
         end
         S_MUL_IL: begin
            mul_a = 33'(integ_gain_ff);
            mul_b = {1'b0, integ_ff[31:0]};
         end
         S_MUL_IH: begin
            mul_a = 33'(integ_gain_ff);
            mul_b = 33'($signed(integ_ff[63:32]));
         end
         S_MUL_D: begin
            mul_a = 33'(deriv_gain_ff);
            mul_b = 33'(r_ff);
         end
         default: begin
            mul_a = 33'(e_ff);
            mul_b = {1'b0, dt_ff};
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   // drive quotient setup: |S| >> frac bits, split at the kept quotient width
   assign div_eff = (out_divisor_ff == '0) ? 16'd1 : out_divisor_ff;
   assign quo_src = mag_ff >> GAIN_FRAC_BITS;
   assign quo_hi  = quo_src >> QUOT_W;
   assign ovf_w   = quo_hi >= ACC_W'(div_eff);

   // divider command
   always_comb begin
      div_req = '0;
      if (state_ff == S_MUL_ED) begin
         div_req.start    = 1'b1;
         div_req.steps    = DIV_CNT_W'(DIV_W);
         div_req.rem_init = '0;
         div_req.dividend = rmag;
         div_req.divisor  = dt_ff;
      end else if (state_ff == S_DDIV_LD) begin
         div_req.start    = !ovf_w;
         div_req.steps    = DIV_CNT_W'(QUOT_W);
         div_req.rem_init = quo_hi[DIV_W-1:0];
         div_req.dividend = DIV_W'(quo_src[QUOT_W-1:0]) << (DIV_W - QUOT_W);
         div_req.divisor  = DIV_W'(div_eff);
      end
   end

   // rate saturation from the quotient magnitude
   always_comb begin
      if (rneg_ff) begin
         r_in = (div_rsp.quotient > 32'h8000_0000) ? 32'sh8000_0000
                                                   : -$signed(div_rsp.quotient);
      end else begin
         r_in = div_rsp.quotient[31] ? 32'sh7fff_ffff : $signed(div_rsp.quotient);
      end
   end

   // drive: floor quotient, center offset, clamp
   always_comb begin
      if (ovf_ff) begin
         qmag = (QUOT_W+1)'(1) << QUOT_W;
      end else begin
         qmag = (QUOT_W+1)'(div_rsp.quotient[QUOT_W-1:0])
              + (QUOT_W+1)'(sneg_ff && (lownz_ff || div_rsp.rem_nz));
      end
      vsum = sneg_ff ? CENTER_V - $signed(VW'(qmag)) : CENTER_V + $signed(VW'(qmag));
      if (vsum < 0) begin
         drive_w = '0;
      end else if (vsum > MAX_V) begin
         drive_w = DRIVE_W'(DRIVE_MAX);
      end else begin
         drive_w = vsum[DRIVE_W-1:0];
      end
   end

   // settle flags
   assign e_w  = 33'(e_ff);
   assign r_w  = 33'(r_ff);
   assign db_w = $signed({2'b00, default_band_ff});
   assign eb_w = $signed({2'b00, error_band_ff});
   assign rb_w = $signed({2'b00, rate_band_ff});
   assign sd_w = (e_w > -db_w) && (e_w < db_w);
   assign sb_w = (e_w > -eb_w) && (e_w < eb_w) && (r_w > -rb_w) && (r_w < rb_w);

   // integral next value
   always_comb begin
      integ_in = integ_ff;
      if (csr_wr_en && csr_index == REG_SETPOINT) begin
         integ_in = '0;
      end else if (state_ff == S_INTEG) begin
         if (isum[64] != isum[63]) begin
            integ_in = isum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
         end else begin
            integ_in = isum[63:0];
         end
      end
   end

   // accumulator of the three gain terms
   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         S_MUL_IL: acc_in = prod_ext;
         S_MUL_IH: acc_in = acc_ff + prod_ext;
         S_MUL_D:  acc_in = acc_ff + (prod_ext <<< 32);
         S_ACC_D:  acc_in = acc_ff + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_PREP;
         S_PREP:    state_in = S_MUL_ED;
         S_MUL_ED:  state_in = S_INTEG;
         S_INTEG:   state_in = S_RDIV;
         S_RDIV:    if (div_rsp.done) state_in = S_MUL_P;
         S_MUL_P:   state_in = S_MUL_IL;
         S_MUL_IL:  state_in = S_MUL_IH;
         S_MUL_IH:  state_in = S_MUL_D;
         S_MUL_D:   state_in = S_ACC_D;
         S_ACC_D:   state_in = S_NEG;
         S_NEG:     state_in = S_DDIV_LD;
         S_DDIV_LD: state_in = ovf_w ? S_FIN : S_DDIV;
         S_DDIV:    if (div_rsp.done) state_in = S_FIN;
         S_FIN:     if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // control state, configuration and history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         setpoint_ff     <= '0;
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         out_divisor_ff  <= 16'd1;
         default_band_ff <= '0;
         error_band_ff   <= '0;
         rate_band_ff    <= '0;
         prev_time_ff    <= '0;
         prev_error_ff   <= '0;
         integ_ff        <= '0;
         r_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         integ_ff <= integ_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_SETPOINT:     setpoint_ff     <= $signed(csr_wdata);
               REG_PROP_GAIN:    prop_gain_ff    <= $signed(csr_wdata);
               REG_INTEG_GAIN:   integ_gain_ff   <= $signed(csr_wdata);
               REG_DERIV_GAIN:   deriv_gain_ff   <= $signed(csr_wdata);
               REG_OUT_DIVISOR:  out_divisor_ff  <= csr_wdata[15:0];
               REG_DEFAULT_BAND: default_band_ff <= csr_wdata[30:0];
               REG_ERROR_BAND:   error_band_ff   <= csr_wdata[30:0];
               REG_RATE_BAND:    rate_band_ff    <= csr_wdata[30:0];
               default: ;
            endcase
         end
         if (state_ff == S_MUL_ED) prev_time_ff <= ts_ff;
         if (state_ff == S_RDIV && div_rsp.done) begin
            r_ff          <= r_in;
            prev_error_ff <= e_ff;
         end
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (req_valid && req_ready) begin
         meas_ff <= req_measurement;
         ts_ff   <= req_timestamp_us;
      end
      if (state_ff == S_PREP) begin
         e_ff  <= meas_ff - setpoint_ff;
         dt_ff <= (dt_raw == '0) ? 32'd1 : dt_raw;
      end
      if (state_ff == S_MUL_ED) rneg_ff <= rdiff[32];
      if (state_ff == S_NEG) begin
         sneg_ff <= acc_ff[ACC_W-1];
         mag_ff  <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      end
      if (state_ff == S_DDIV_LD) begin
         ovf_ff   <= ovf_w;
         lownz_ff <= (mag_ff & FRAC_MASK) != '0;
      end
      if (state_ff == S_FIN && out_free) begin
         rsp_drive_ff <= drive_w;
         rsp_error_ff <= e_ff;
         rsp_rate_ff  <= r_ff;
         rsp_sd_ff    <= sd_w;
         rsp_sb_ff    <= sb_w;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive           = rsp_drive_ff;
   assign rsp_error_now       = rsp_error_ff;
   assign rsp_rate_now        = rsp_rate_ff;
   assign rsp_settled_default = rsp_sd_ff;
   assign rsp_settled_both    = rsp_sb_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PREP)
      else $error("accepted item did not start the sequence");
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_RDIV || state_ff == S_DDIV))
      else $error("divider finished outside a divide state");
   a_setpoint_clears: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == REG_SETPOINT |=> integ_ff == '0)
      else $error("setpoint write did not clear the integral");
   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result appeared outside the final state");

endmodule

### dv/pid_servo_controller_check.sv
// checker for the pid servo controller: predicts every result and compares it on arrival
`timescale 1ns / 1ps
module pid_servo_controller_check
   import psc_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16,
   parameter int DRIVE_MAX      = 180,
   parameter int DRIVE_CENTER   = 90,
   localparam int DRIVE_W       = $clog2(DRIVE_MAX + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_measurement,
   input  logic [31:0]        req_timestamp_us,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [DRIVE_W-1:0] rsp_drive,
   input  logic signed [31:0] rsp_error_now,
   input  logic signed [31:0] rsp_rate_now,
   input  logic               rsp_settled_default,
   input  logic               rsp_settled_both,
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 outstanding,
   output int                 fail_count
);

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic signed [31:0] error_now;
      logic signed [31:0] rate_now;
      logic               settled_default;
      logic               settled_both;
   } servo_result_type;

   // register copies
   logic signed [31:0] setpoint_q, kp_q, ki_q, kd_q;
   logic [15:0]        divisor_q;
   logic [30:0]        band_default_q, band_error_q, band_rate_q;

   // loop history
   logic [31:0]        last_stamp;
   logic signed [31:0] last_error;
   logic signed [63:0] error_area;

   servo_result_type awaited_results[$];
   servo_result_type oldest;
   int               mismatches = 0;

   // one control step: updates the history and returns the result it should produce
   function servo_result_type servo_step(input logic signed [31:0] meas,
                                         input logic [31:0] stamp);
      servo_result_type    res;
      logic signed [31:0]  err, rate;
      logic [31:0]         dt32;
      longint              span, area, delta, quot, level, pace, bd, be, br;
      logic signed [64:0]  area_sum;
      logic signed [127:0] pid_sum, denom, steps;

      err  = meas - setpoint_q;
      dt32 = stamp - last_stamp;
      // no elapsed time counts as one microsecond
      span = (dt32 == 32'd0) ? 64'sd1 : longint'({32'd0, dt32});

      // integral of error over time, saturating at the 64-bit bounds
      area     = err * span;
      area_sum = error_area + area;
      if (area_sum[64:63] == 2'b01) error_area = {1'b0, {63{1'b1}}};
      else if (area_sum[64:63] == 2'b10) error_area = {1'b1, {63{1'b0}}};
      else error_area = area_sum[63:0];

      // rate truncates toward zero, saturating at the 32-bit bounds
      delta = longint'(err) - longint'(last_error);
      quot  = delta / span;
      if (quot > 64'sd2147483647) rate = 32'h7FFF_FFFF;
      else if (quot < -64'sd2147483648) rate = 32'h8000_0000;
      else rate = quot[31:0];

      // exact pid sum, floor division by divisor times gain scale, then offset and clamp
      pid_sum = kp_q * err + ki_q * error_area + kd_q * rate;
      denom   = divisor_q;
      if (denom == 0) denom = 1;
      denom = denom <<< GAIN_FRAC_BITS;
      steps = pid_sum / denom;
      if (pid_sum < 0 && pid_sum % denom != 0) steps = steps - 1;
      steps = steps + DRIVE_CENTER;
      if (steps < 0) res.drive = '0;
      else if (steps > DRIVE_MAX) res.drive = DRIVE_W'(DRIVE_MAX);
      else res.drive = steps[DRIVE_W-1:0];

      // settle flags use strict bounds on both sides
      level = err;
      pace  = rate;
      bd    = band_default_q;
      be    = band_error_q;
      br    = band_rate_q;
      res.error_now       = err;
      res.rate_now        = rate;
      res.settled_default = (level > -bd) && (level < bd);
      res.settled_both    = (level > -be) && (level < be) && (pace > -br) && (pace < br);

      last_stamp = stamp;
      last_error = err;
      return res;
   endfunction

   task check_field(input string name, input logic signed [63:0] want,
                    input logic signed [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // follow register writes, queue a prediction per accepted item, check each result
   always @(posedge clock) begin
      if (reset) begin
         setpoint_q     = '0;
         kp_q           = '0;
         ki_q           = '0;
         kd_q           = '0;
         divisor_q      = 16'd1;
         band_default_q = '0;
         band_error_q   = '0;
         band_rate_q    = '0;
         last_stamp     = '0;
         last_error     = '0;
         error_area     = '0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_SETPOINT: begin
                  setpoint_q = csr_wdata;
                  error_area = '0;
               end
               REG_PROP_GAIN:    kp_q = csr_wdata;
               REG_INTEG_GAIN:   ki_q = csr_wdata;
               REG_DERIV_GAIN:   kd_q = csr_wdata;
               REG_OUT_DIVISOR:  divisor_q = csr_wdata[15:0];
               REG_DEFAULT_BAND: band_default_q = csr_wdata[30:0];
               REG_ERROR_BAND:   band_error_q = csr_wdata[30:0];
               REG_RATE_BAND:    band_rate_q = csr_wdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_results.push_back(servo_step(req_measurement, req_timestamp_us));
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual drive %0d error %0d",
                        $time, rsp_drive, rsp_error_now);
            end else begin
               oldest = awaited_results.pop_front();
               check_field("drive", oldest.drive, rsp_drive);
               check_field("error_now", oldest.error_now, rsp_error_now);
               check_field("rate_now", oldest.rate_now, rsp_rate_now);
               check_field("settled_default", oldest.settled_default, rsp_settled_default);
               check_field("settled_both", oldest.settled_both, rsp_settled_both);
            end
         end
      end
      outstanding <= awaited_results.size();
      fail_count  <= mismatches;
   end

endmodule

### dv/pid_servo_controller_test.sv
// testbench top for the pid servo controller: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module pid_servo_controller_test;
   import psc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 150;
   localparam int PHASE_ITEMS    = 48;
   localparam int RANDOM_PHASES  = 11;

   typedef enum int {TRACKING, WIDE, DRIFT} profile_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_measurement = '0;
   logic [31:0]        req_timestamp_us = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic [7:0]         rsp_drive;
   logic signed [31:0] rsp_error_now, rsp_rate_now;
   logic               rsp_settled_default, rsp_settled_both;
   logic               csr_wr_en = 1'b0;
   csr_index_type      csr_index = REG_SETPOINT;
   logic [31:0]        csr_wdata = '0;

   int          outstanding, fail_count;
   logic        idle_on = 1'b0;
   int          stall_left = 0;
   logic [31:0] stamp = '0;

   pid_servo_controller dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_measurement(req_measurement), .req_timestamp_us(req_timestamp_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_drive(rsp_drive),
      .rsp_error_now(rsp_error_now), .rsp_rate_now(rsp_rate_now),
      .rsp_settled_default(rsp_settled_default), .rsp_settled_both(rsp_settled_both),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pid_servo_controller_check servo_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_measurement(req_measurement), .req_timestamp_us(req_timestamp_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_drive(rsp_drive),
      .rsp_error_now(rsp_error_now), .rsp_rate_now(rsp_rate_now),
      .rsp_settled_default(rsp_settled_default), .rsp_settled_both(rsp_settled_both),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .outstanding(outstanding), .fail_count(fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ends the run when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("pid_servo_controller regression: fail");
      $finish;
   end

   // random value in -mag..mag as a 32-bit pattern
   function automatic logic [31:0] signed_spread(input int unsigned mag);
      return $urandom_range(0, 2 * mag) - mag;
   endfunction

   // offer one item, with an occasional gap before it; returns at the accepting edge
   task automatic send_sample(input logic [31:0] meas, input logic [31:0] ts);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_measurement  <= meas;
      req_timestamp_us <= ts;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every predicted result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input bit with_sp, input logic [31:0] sp, kp, ki, kd,
                                input logic [31:0] div, bd, be, br);
      if (with_sp) write_reg(REG_SETPOINT, sp);
      write_reg(REG_PROP_GAIN, kp);
      write_reg(REG_INTEG_GAIN, ki);
      write_reg(REG_DERIV_GAIN, kd);
      write_reg(REG_OUT_DIVISOR, div);
      write_reg(REG_DEFAULT_BAND, bd);
      write_reg(REG_ERROR_BAND, be);
      write_reg(REG_RATE_BAND, br);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int          phase, n;
      int          clamp_offsets[8];
      profile_type profile;
      bit          with_sp;
      logic [31:0] sp, kp, ki, kd, div, bd, be, br, meas;

      clamp_offsets = '{90, 91, -91, -90, 5, 4, -4, -5};
      sp = '0;
      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;

      // reset settings: zero elapsed time, measurement extremes, rate saturating both ways
      send_sample(32'h0000_0000, 32'd0);
      send_sample(32'h7FFF_FFFF, 32'd1);
      send_sample(32'h8000_0000, 32'd2);
      send_sample(32'h7FFF_FFFF, 32'd3);
      send_sample(32'h7FFF_FFFF, 32'd3);
      wait_drained();

      // extreme gains, zero divisor, widest bands; huge elapsed times drive the integral
      // into positive then negative saturation, then the timestamp wraps forward
      load_settings(1'b1, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF, 32'd2);
      send_sample(32'h7FFF_FFFF, 32'd1);
      send_sample(32'h7FFF_FFFF, 32'd0);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF);
      send_sample(32'h8000_0000, 32'hFFFF_FFFE);
      send_sample(32'h8000_0000, 32'hFFFF_FFFD);
      send_sample(32'h0000_0000, 32'h0000_0005);
      wait_drained();

      // unity gain at the most negative setpoint: error wraps, drive clamps, band edges
      sp    = 32'h8000_0000;
      stamp = 32'd5;
      load_settings(1'b1, sp, 32'h0001_0000, 32'h0, 32'h0, 32'd1, 32'd5, 32'd10, 32'd3);
      for (n = 0; n < 8; n++) begin
         stamp = stamp + 32'd10;
         send_sample(sp + clamp_offsets[n], stamp);
      end
      wait_drained();

      // half gain for floor rounding of negative sums; masked upper register bits
      sp = '0;
      load_settings(1'b1, sp, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                    32'hABCD_0002, 32'h8000_0010, 32'hFFFF_FFFF, 32'h8000_0002);
      stamp = stamp + 32'd1000;
      send_sample(32'hFFFF_FFFF, stamp);
      stamp = stamp + 32'd1000;
      send_sample(32'h0000_0001, stamp);
      stamp = stamp + 32'd1000;
      send_sample(32'hFFFF_FFFD, stamp);
      wait_drained();

      // random phases, each with fresh settings; every fourth phase and the last two run without idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         profile = profile_type'(phase % 3);
         idle_on <= (phase < RANDOM_PHASES - 2) && (phase % 4 != 3);
         with_sp = $urandom_range(0, 3) != 0;
         case (profile)
            TRACKING: begin
               if (with_sp) sp = signed_spread(32'h0010_0000);
               kp  = signed_spread(32'h0004_0000);
               ki  = signed_spread(64);
               kd  = signed_spread(32'h0004_0000);
               div = $urandom_range(1, 300);
               bd  = $urandom_range(0, 3000);
               be  = $urandom_range(0, 3000);
               br  = $urandom_range(0, 20);
            end
            WIDE: begin
               if (with_sp) sp = $urandom;
               kp  = $urandom;
               ki  = $urandom;
               kd  = $urandom;
               div = $urandom & (($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : 32'hFFFF_FFFF);
               bd  = $urandom;
               be  = $urandom;
               br  = $urandom;
            end
            default: begin
               if (with_sp) sp = $urandom;
               kp  = signed_spread(32'h2000);
               ki  = signed_spread(4);
               kd  = signed_spread(32'h0001_0000);
               div = ($urandom_range(0, 3) == 0) ? 32'h0000_FFFF : $urandom_range(1, 65535);
               bd  = $urandom_range(0, 200);
               be  = $urandom_range(0, 200);
               br  = $urandom_range(0, 2);
            end
         endcase
         load_settings(with_sp, sp, kp, ki, kd, div, bd, be, br);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            case (profile)
               // small errors around the setpoint at irregular sample intervals, some noise
               TRACKING: begin
                  if ($urandom_range(0, 6) == 0) begin
                     meas  = $urandom;
                     stamp = $urandom;
                  end else begin
                     meas = sp + signed_spread(2000);
                     if ($urandom_range(0, 11) != 0) stamp = stamp + $urandom_range(1, 3000);
                  end
               end
               // anything goes, with repeated timestamps now and then
               WIDE: begin
                  meas = $urandom;
                  if ($urandom_range(0, 5) != 0) stamp = $urandom;
               end
               // long intervals that wrap the timestamp, occasional step back in time
               default: begin
                  if ($urandom_range(0, 9) == 0) begin
                     meas  = $urandom;
                     stamp = stamp - 32'd1;
                  end else begin
                     meas  = sp + signed_spread(150);
                     stamp = stamp + $urandom_range(0, 32'h4000_0000);
                  end
               end
            endcase
            send_sample(meas, stamp);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("pid_servo_controller regression: pass");
      end else begin
         $display("pid_servo_controller regression: fail");
      end
      $finish;
   end

endmodule
